@@ design/button_click_classifier_top_defines.svh @@
// Assertion macros for the button click classifier.
// Included by the files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH

// Checked on every rising clock edge, ignored while reset is asserted.
`define BCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ design/bcc_pkg.sv @@
// Shared types and constants for the button click classifier.
// No dependencies; used by the output channel interface and the top level.
`timescale 1ns / 1ps

package bcc_pkg;

  localparam int TimerWidth = 24;
  localparam int RegW       = 24;
  localparam int EventW     = 2;
  localparam int AddrW      = 4;
  localparam int DataW      = 32;

  localparam logic [RegW-1:0] LongTicksRst   = 24'd1000000;
  localparam logic [RegW-1:0] DoubleWinRst   = 24'd500000;
  localparam logic [RegW-1:0] MinClickRst    = 24'd50000;

  typedef enum logic [EventW-1:0] {
    CLICK_NONE   = 2'd0,
    CLICK_SINGLE = 2'd1,
    CLICK_DOUBLE = 2'd2,
    CLICK_LONG   = 2'd3
  } click_e;

  typedef enum logic [1:0] {
    REG_LONG_TICKS   = 2'd0,
    REG_DOUBLE_WIN   = 2'd1,
    REG_MIN_CLICK    = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_e;

endpackage

@@ design/bcc_in_if.sv @@
// Input channel of the button click classifier: one tick request with two button levels.
// Depends on nothing but the handshake convention valid/ready.
`timescale 1ns / 1ps

interface bcc_in_if;
  logic valid;
  logic ready;
  logic button_a;
  logic button_b;

  modport source (output valid, output button_a, output button_b, input ready);
  modport sink (input valid, input button_a, input button_b, output ready);
endinterface

@@ design/bcc_out_if.sv @@
// Output channel of the button click classifier: one result request per tick.
// Depends on bcc_pkg for the event width.
`timescale 1ns / 1ps

interface bcc_out_if;
  logic                       valid;
  logic                       ready;
  logic [bcc_pkg::EventW-1:0] click_event;
  logic                       lamp_on;

  modport source (output valid, output click_event, output lamp_on, input ready);
  modport sink (input valid, input click_event, input lamp_on, output ready);
endinterface

@@ design/button_click_classifier_top.sv @@
// Top level of the button click classifier: timers, classification and APB registers.
// Depends on bcc_pkg, bcc_in_if, bcc_out_if and button_click_classifier_top_defines.svh.
//
//   Channel   Direction  Carries
//   in_i      sink       button_a, button_b (one timer tick per request)
//   out_o     source     click_event, lamp_on (one result per tick)
//   APB       slave      long_ticks @0x0, double_window_ticks @0x4, min_click_ticks @0x8
//
// Every tick request is classified in the cycle it is accepted, and its result is
// registered into a single output stage, so one request per cycle is sustained while the output is ready.
// The input is ready whenever the output stage is empty or is being emptied in the
// same cycle; a stalled output therefore stalls the input after one buffered result.
// Reset is asynchronous and active low; it restores the default thresholds and
// clears both timers, the double-click flag and the output valid flag. No pass over
// storage is needed after reset.
`timescale 1ns / 1ps
`include "button_click_classifier_top_defines.svh"

module button_click_classifier_top #(
  parameter int TIMER_WIDTH = bcc_pkg::TimerWidth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bcc_in_if.sink                     in_i,
  bcc_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bcc_pkg::AddrW-1:0]  paddr,
  input  logic [bcc_pkg::DataW-1:0]  pwdata,
  output logic [bcc_pkg::DataW-1:0]  prdata,
  output logic                       pready
);

  // Comparisons run at the wider of the timer and the threshold widths, so a
  // narrow timer simply never reaches a large threshold.
  localparam int CmpW = (TIMER_WIDTH > bcc_pkg::RegW) ? TIMER_WIDTH : bcc_pkg::RegW;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  // Configuration registers.
  logic [bcc_pkg::RegW-1:0] long_ticks_q, double_win_q, min_click_q;
  bcc_pkg::reg_idx_e        reg_idx;
  logic                     reg_wr;

  // Classifier state.
  logic                   press_active_q, press_active_d;
  logic [TIMER_WIDTH-1:0] press_elapsed_q, press_elapsed_d;
  logic                   release_active_q, release_active_d;
  logic [TIMER_WIDTH-1:0] release_elapsed_q, release_elapsed_d;
  logic                   double_armed_q, double_armed_d;

  // Output stage.
  logic              out_valid_q;
  bcc_pkg::click_e   event_q, event_d;
  logic              lamp_q;

  logic                   in_accept;
  logic                   pressed;
  logic [TIMER_WIDTH-1:0] press_adv, release_adv;

  // APB access: always ready, register index from the word address.
  assign pready  = 1'b1;
  assign reg_idx = bcc_pkg::reg_idx_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q <= bcc_pkg::LongTicksRst;
      double_win_q <= bcc_pkg::DoubleWinRst;
      min_click_q  <= bcc_pkg::MinClickRst;
    end else if (reg_wr) begin
      case (reg_idx)
        bcc_pkg::REG_LONG_TICKS: long_ticks_q <= pwdata[bcc_pkg::RegW-1:0];
        bcc_pkg::REG_DOUBLE_WIN: double_win_q <= pwdata[bcc_pkg::RegW-1:0];
        bcc_pkg::REG_MIN_CLICK:  min_click_q  <= pwdata[bcc_pkg::RegW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bcc_pkg::REG_LONG_TICKS: prdata = bcc_pkg::DataW'(long_ticks_q);
      bcc_pkg::REG_DOUBLE_WIN: prdata = bcc_pkg::DataW'(double_win_q);
      bcc_pkg::REG_MIN_CLICK:  prdata = bcc_pkg::DataW'(min_click_q);
      default:                 prdata = '0;
    endcase
  end

  // The input may advance whenever the output stage can take a new result.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;
  assign pressed    = in_i.button_a || in_i.button_b;

  // Active timers advance first on every tick and hold at their maximum.
  assign press_adv = !press_active_q ? press_elapsed_q :
                     (press_elapsed_q == TimerMax) ? TimerMax :
                     press_elapsed_q + TIMER_WIDTH'(1);
  assign release_adv = !release_active_q ? release_elapsed_q :
                       (release_elapsed_q == TimerMax) ? TimerMax :
                       release_elapsed_q + TIMER_WIDTH'(1);

  // Classification of one tick.
  always_comb begin
    press_active_d    = press_active_q;
    press_elapsed_d   = press_adv;
    release_active_d  = release_active_q;
    release_elapsed_d = release_adv;
    double_armed_d    = double_armed_q;
    event_d           = bcc_pkg::CLICK_NONE;

    if (pressed) begin
      if (!press_active_q) begin
        // A new press; if it comes soon enough after a short click, arm a double.
        press_active_d  = 1'b1;
        press_elapsed_d = '0;
        if (release_active_q && (CmpW'(release_adv) <= CmpW'(double_win_q))) begin
          double_armed_d = 1'b1;
        end
      end
    end else if (press_active_q) begin
      // Release edge: classify the press by its duration.
      if (CmpW'(press_adv) >= CmpW'(long_ticks_q)) begin
        event_d = bcc_pkg::CLICK_LONG;
        // An armed double is dropped with its release timer; otherwise the
        // release timer keeps running and may still report a single click.
        if (double_armed_q) begin
          double_armed_d    = 1'b0;
          release_active_d  = 1'b0;
          release_elapsed_d = '0;
        end
      end else if (CmpW'(press_adv) > CmpW'(min_click_q)) begin
        if (double_armed_q) begin
          event_d           = bcc_pkg::CLICK_DOUBLE;
          double_armed_d    = 1'b0;
          release_active_d  = 1'b0;
          release_elapsed_d = '0;
        end else begin
          release_active_d  = 1'b1;
          release_elapsed_d = '0;
        end
      end
      press_active_d  = 1'b0;
      press_elapsed_d = '0;
    end else if (release_active_q && (CmpW'(release_adv) > CmpW'(double_win_q))) begin
      // No second press came inside the window: it was a single click.
      event_d           = bcc_pkg::CLICK_SINGLE;
      release_active_d  = 1'b0;
      release_elapsed_d = '0;
      double_armed_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_active_q    <= 1'b0;
      press_elapsed_q   <= '0;
      release_active_q  <= 1'b0;
      release_elapsed_q <= '0;
      double_armed_q    <= 1'b0;
    end else if (in_accept) begin
      press_active_q    <= press_active_d;
      press_elapsed_q   <= press_elapsed_d;
      release_active_q  <= release_active_d;
      release_elapsed_q <= release_elapsed_d;
      double_armed_q    <= double_armed_d;
    end
  end

  // Output stage: valid is control and reset; the payload only loads on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      event_q <= event_d;
      lamp_q  <= !pressed;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.click_event = event_q;
  assign out_o.lamp_on     = lamp_q;

  // An idle timer always reads zero.
  `BCC_ASSERT_ALWAYS(a_press_idle_zero, !press_active_q |-> (press_elapsed_q == '0),
                     "press timer nonzero while idle")
  `BCC_ASSERT_ALWAYS(a_release_idle_zero, !release_active_q |-> (release_elapsed_q == '0),
                     "release timer nonzero while idle")
  // Every click is reported on a released tick.
  `BCC_ASSERT(a_event_released,
              (out_valid_q && (event_q != bcc_pkg::CLICK_NONE)) |-> lamp_q,
              "click reported while pressed")
  // The press timer runs exactly while the last accepted tick was pressed.
  `BCC_ASSERT(a_press_tracks_input, in_accept |=> (press_active_q == $past(pressed)),
              "press state does not follow the button")
  // An accepted tick always leaves a result in the output stage.
  `BCC_ASSERT(a_result_after_accept, in_accept |=> out_valid_q,
              "accepted tick produced no result")

endmodule
